// File: src/tksl_pkg.sv
// ----------------------------------------------------------------------------
// tksl_pkg: shared types and constants
// Field widths, command and register codes and the broadcast control word
// that the top level hands to every list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package tksl_pkg;

    localparam int DEF_LIST_DEPTH = 64;
    localparam int DEF_COORD_BITS = 12;

    localparam int SCORE_W = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] MAX_POINTS_RESET = 7'd64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic REG_MAX_POINTS = 1'b0;

    typedef struct packed {
        logic                      place;
        logic                      grow;
        logic                      append;
        logic signed [SCORE_W-1:0] score;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/tksl_if.sv
// ----------------------------------------------------------------------------
// tksl_if: point list channels
// Valid/ready channels for command beats into the list and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksl_in_if #(
    parameter int COORD_BITS = tksl_pkg::DEF_COORD_BITS
);
    import tksl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [COORD_BITS-1:0]     point_row;
    logic [COORD_BITS-1:0]     point_col;
    logic signed [SCORE_W-1:0] point_score;
    logic [RANK_W-1:0]         read_rank;

    modport source (
        output valid, command, point_row, point_col, point_score, read_rank,
        input  ready
    );
    modport sink (
        input  valid, command, point_row, point_col, point_score, read_rank,
        output ready
    );
endinterface

interface tksl_out_if #(
    parameter int COORD_BITS = tksl_pkg::DEF_COORD_BITS
);
    import tksl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [RANK_W-1:0]         insert_rank;
    logic                      dropped;
    logic [COUNT_W-1:0]        entry_count;
    logic                      read_valid;
    logic [COORD_BITS-1:0]     out_row;
    logic [COORD_BITS-1:0]     out_col;
    logic signed [SCORE_W-1:0] out_score;

    modport source (
        output valid, accepted, insert_rank, dropped, entry_count, read_valid,
               out_row, out_col, out_score,
        input  ready
    );
    modport sink (
        input  valid, accepted, insert_rank, dropped, entry_count, read_valid,
               out_row, out_col, out_score,
        output ready
    );
endinterface

`default_nettype wire

// File: src/tksl_cfg.sv
// ----------------------------------------------------------------------------
// tksl_cfg: configuration register file
// APB-style slave holding the list capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksl_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tksl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tksl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tksl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [tksl_pkg::COUNT_W-1:0]      o_max_points
);
    import tksl_pkg::*;

    logic               rd_sel;
    logic [COUNT_W-1:0] r_max;
    logic               wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_POINTS_RESET;
        end else if (wr_hit) begin
            r_max <= pwdata[COUNT_W-1:0];
        end
    end

    assign rd_sel       = (paddr[2] == REG_MAX_POINTS);
    assign prdata       = rd_sel ? {{(APB_DATA_W-COUNT_W){1'b0}}, r_max}
                                 : '0;
    assign pready       = 1'b1;
    assign o_max_points = r_max;

endmodule

`default_nettype wire

// File: src/tksl_cell.sv
// ----------------------------------------------------------------------------
// tksl_cell: one rank of the sorted list
// Holds one entry and its valid bit; on an insert it keeps its entry, takes
// the new point or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tksl_cell #(
    parameter int COORD_BITS = tksl_pkg::DEF_COORD_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tksl_pkg::t_cell_ctl                i_ctl,
    input  wire logic [COORD_BITS-1:0]              i_new_row,
    input  wire logic [COORD_BITS-1:0]              i_new_col,
    input  wire logic [COORD_BITS-1:0]              i_prev_row,
    input  wire logic [COORD_BITS-1:0]              i_prev_col,
    input  wire logic signed [tksl_pkg::SCORE_W-1:0] i_prev_score,
    input  wire logic                               i_prev_before,
    input  wire logic                               i_prev_valid,
    input  wire logic                               i_next_valid,
    output logic      [COORD_BITS-1:0]              o_row,
    output logic      [COORD_BITS-1:0]              o_col,
    output logic signed [tksl_pkg::SCORE_W-1:0]     o_score,
    output logic                                    o_valid,
    output logic                                    o_before,
    output logic                                    o_tail_le,
    output logic                                    o_take
);
    import tksl_pkg::*;

    logic [COORD_BITS-1:0]     r_row;
    logic [COORD_BITS-1:0]     r_col;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_valid;
    logic                      above;

    // entries above the new score, or every held entry when appending
    assign above     = r_valid && (r_score > i_ctl.score);
    assign o_before  = r_valid && (above || i_ctl.append);
    assign o_tail_le = r_valid && !i_next_valid && (i_ctl.score <= r_score);
    assign o_take    = !o_before && i_prev_before;

    always_ff @(posedge i_clk) begin
        if (i_ctl.place && !o_before) begin
            if (i_prev_before) begin
                r_row   <= i_new_row;
                r_col   <= i_new_col;
                r_score <= i_ctl.score;
            end else begin
                r_row   <= i_prev_row;
                r_col   <= i_prev_col;
                r_score <= i_prev_score;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.grow && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_score = r_score;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: src/top_k_sorted_point_list.sv
// ----------------------------------------------------------------------------
// top_k_sorted_point_list: best-score feature point list
// Row of rank cells kept in descending score order, with a two-beat result
// buffer and an APB capacity register.
// ----------------------------------------------------------------------------
// usage
//   i_in carries command beats: an insert brings row, column and signed
//   score, a read brings a rank. every accepted beat yields exactly one
//   result beat on o_out, in order.
//   an insert is compared against all cells at once, and each cell keeps,
//   takes the new point or takes its left neighbor's entry at the same edge,
//   so one beat is taken per cycle while i_in.ready is high.
//   results wait in a two-beat output buffer; i_in.ready drops only when
//   both slots are full, so a stalled receiver costs one extra beat of slack.
//   reset clears all valid bits, the entry count and the output buffer, and
//   sets the capacity register to 64. entry data is not cleared.
//   max_points is written over APB at byte address 0 while the block idles,
//   a rule on the user that the block itself does not enforce; 0 acts as 1,
//   values above LIST_DEPTH act as LIST_DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_point_list #(
    parameter int LIST_DEPTH = tksl_pkg::DEF_LIST_DEPTH,
    parameter int COORD_BITS = tksl_pkg::DEF_COORD_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tksl_in_if.sink                                i_in,
    tksl_out_if.source                             o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tksl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tksl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tksl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import tksl_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef struct packed {
        logic                      accepted;
        logic [RANK_W-1:0]         insert_rank;
        logic                      dropped;
        logic [COUNT_W-1:0]        entry_count;
        logic                      read_valid;
        logic [COORD_BITS-1:0]     out_row;
        logic [COORD_BITS-1:0]     out_col;
        logic signed [SCORE_W-1:0] out_score;
    } t_result;

    logic [COUNT_W-1:0]        max_points;
    logic [CNT_W-1:0]          cap;
    logic [CNT_W-1:0]          r_held;
    logic [CNT_W-1:0]          n_held;
    logic                      beat_in;
    logic                      is_insert;
    logic                      full;
    logic                      append;
    logic                      reject;
    t_cell_ctl                 ctl;
    logic [IDX_W-1:0]          pos;
    logic                      rd_hit;
    logic [IDX_W-1:0]          rd_idx;
    t_result                   res;
    t_result                   r_main;
    t_result                   r_skid;
    logic                      r_main_valid;
    logic                      r_skid_valid;
    logic                      pop;

    logic [COORD_BITS-1:0]     c_row    [LIST_DEPTH];
    logic [COORD_BITS-1:0]     c_col    [LIST_DEPTH];
    logic signed [SCORE_W-1:0] c_score  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]     c_valid;
    logic [LIST_DEPTH-1:0]     c_before;
    logic [LIST_DEPTH-1:0]     c_tail_le;
    logic [LIST_DEPTH-1:0]     c_take;

    tksl_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_points (max_points)
    );

    always_comb begin
        if (max_points == '0) begin
            cap = CNT_W'(1);
        end else if (int'(max_points) > LIST_DEPTH) begin
            cap = CNT_W'(LIST_DEPTH);
        end else begin
            cap = CNT_W'(max_points);
        end
    end

    assign beat_in    = i_in.valid && i_in.ready;
    assign is_insert  = (i_in.command == CMD_INSERT);
    assign full       = (r_held >= cap);
    assign append     = |c_tail_le;
    assign reject     = full && append;

    assign ctl.place  = beat_in && is_insert && !reject;
    assign ctl.grow   = beat_in && is_insert && !reject && !full;
    assign ctl.append = append;
    assign ctl.score  = i_in.point_score;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            logic [COORD_BITS-1:0]     prev_row;
            logic [COORD_BITS-1:0]     prev_col;
            logic signed [SCORE_W-1:0] prev_score;
            logic                      prev_before;
            logic                      prev_valid;
            logic                      next_valid;

            if (g == 0) begin : g_head
                assign prev_row    = i_in.point_row;
                assign prev_col    = i_in.point_col;
                assign prev_score  = i_in.point_score;
                assign prev_before = 1'b1;
                assign prev_valid  = 1'b1;
            end else begin : g_body
                assign prev_row    = c_row[g-1];
                assign prev_col    = c_col[g-1];
                assign prev_score  = c_score[g-1];
                assign prev_before = c_before[g-1];
                assign prev_valid  = c_valid[g-1];
            end

            if (g == LIST_DEPTH - 1) begin : g_last
                assign next_valid = 1'b0;
            end else begin : g_mid
                assign next_valid = c_valid[g+1];
            end

            tksl_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_new_row     (i_in.point_row),
                .i_new_col     (i_in.point_col),
                .i_prev_row    (prev_row),
                .i_prev_col    (prev_col),
                .i_prev_score  (prev_score),
                .i_prev_before (prev_before),
                .i_prev_valid  (prev_valid),
                .i_next_valid  (next_valid),
                .o_row         (c_row[g]),
                .o_col         (c_col[g]),
                .o_score       (c_score[g]),
                .o_valid       (c_valid[g]),
                .o_before      (c_before[g]),
                .o_tail_le     (c_tail_le[g]),
                .o_take        (c_take[g])
            );
        end
    endgenerate

    always_comb begin
        pos = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (c_take[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign n_held = ctl.grow ? (r_held + CNT_W'(1)) : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    assign rd_hit = (CMP_W'(i_in.read_rank) < CMP_W'(r_held));
    assign rd_idx = IDX_W'(i_in.read_rank);

    always_comb begin
        res             = '0;
        res.entry_count = COUNT_W'(n_held);
        if (is_insert) begin
            if (!reject) begin
                res.accepted    = 1'b1;
                res.insert_rank = RANK_W'(pos);
                res.dropped     = full;
            end
        end else if (rd_hit) begin
            res.read_valid = 1'b1;
            res.out_row    = c_row[rd_idx];
            res.out_col    = c_col[rd_idx];
            res.out_score  = c_score[rd_idx];
        end
    end

    // two-beat result buffer
    assign pop        = r_main_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (beat_in) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (beat_in) begin
            if (r_main_valid && !pop) begin
                r_skid <= res;
            end else begin
                r_main <= res;
            end
        end
    end

    assign o_out.valid       = r_main_valid;
    assign o_out.accepted    = r_main.accepted;
    assign o_out.insert_rank = r_main.insert_rank;
    assign o_out.dropped     = r_main.dropped;
    assign o_out.entry_count = r_main.entry_count;
    assign o_out.read_valid  = r_main.read_valid;
    assign o_out.out_row     = r_main.out_row;
    assign o_out.out_col     = r_main.out_col;
    assign o_out.out_score   = r_main.out_score;

endmodule

`default_nettype wire

// File: src/tksl_checker.sv
// ----------------------------------------------------------------------------
// tksl_checker: result port checks
// Watches the result channel of the point list and flags inconsistent beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tksl_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_ready,
    input  wire logic                          i_accepted,
    input  wire logic [tksl_pkg::RANK_W-1:0]   i_insert_rank,
    input  wire logic                          i_dropped,
    input  wire logic                          i_read_valid
);
    import tksl_pkg::*;

    a_reset_clears_out : assert property (
        @(posedge i_clk) !i_rst_n |=> !i_valid
    ) else $error("result beat valid right after reset");

    a_drop_needs_accept : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dropped |-> i_accepted
    ) else $error("entry dropped without an accepted insert");

    a_read_not_insert : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_read_valid |-> !i_accepted && !i_dropped && (i_insert_rank == '0)
    ) else $error("read beat carries insert fields");

    a_stall_holds : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_accepted) && $stable(i_dropped)
                               && $stable(i_insert_rank) && $stable(i_read_valid)
    ) else $error("stalled result beat changed");

endmodule

bind top_k_sorted_point_list tksl_checker u_tksl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_accepted    (o_out.accepted),
    .i_insert_rank (o_out.insert_rank),
    .i_dropped     (o_out.dropped),
    .i_read_valid  (o_out.read_valid)
);

`default_nettype wire

// File: tb/sv/tb_top_k_sorted_point_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_point_list: self-checking bench for the top-k point list
// Drives insert and read beats through the command channel and scores each
// result beat against a behavioral copy of the sorted list or, for directed
// beats, a tabled result, with the capacity register reprogrammed over APB
// between phases and random idling on both sides of the channels.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_point_list;
    import tksl_pkg::*;

    localparam int DEPTH        = DEF_LIST_DEPTH;
    localparam int CB           = DEF_COORD_BITS;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BEATS  = 233;
    localparam int NUM_PHASES   = 7;
    localparam int LONG_HOLD    = 200;

    localparam logic signed [SCORE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                      cmd;
        logic [CB-1:0]             row;
        logic [CB-1:0]             col;
        logic signed [SCORE_W-1:0] score;
        logic [RANK_W-1:0]         rank;
    } t_point_cmd;

    typedef struct packed {
        logic                      accepted;
        logic [RANK_W-1:0]         insert_rank;
        logic                      dropped;
        logic [COUNT_W-1:0]        entry_count;
        logic                      read_valid;
        logic [CB-1:0]             out_row;
        logic [CB-1:0]             out_col;
        logic signed [SCORE_W-1:0] out_score;
    } t_list_result;

    typedef enum logic { ROW_BEAT, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        t_point_cmd   beat;
        bit           known;
        t_list_result res;
        int           cap_value;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tksl_in_if  #(.COORD_BITS(CB)) cmd_ch ();
    tksl_out_if #(.COORD_BITS(CB)) res_ch ();

    top_k_sorted_point_list #(
        .LIST_DEPTH (DEPTH),
        .COORD_BITS (CB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // behavioral copy of the list
    logic [CB-1:0]             kept_row   [DEPTH];
    logic [CB-1:0]             kept_col   [DEPTH];
    logic signed [SCORE_W-1:0] kept_score [DEPTH];
    int                        held;
    logic [COUNT_W-1:0]        cap_reg;

    t_list_result pending_results [$];
    t_plan_row    plan [$];

    bit           beat_known;
    t_list_result beat_res;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_reqs;
    int           hold_seen;
    int           hold_left;
    int           mismatches;
    int           cycle_count;

    int phase_cap [0:NUM_PHASES-1] = '{10, 1, 30, 0, 64, 127, 20};

    function automatic t_list_result list_apply(t_point_cmd c);
        t_list_result r;
        int cap;
        int pos;
        int newc;
        int i;
        bit full;
        bit place;
        r = '0;
        if (c.cmd == CMD_INSERT) begin
            cap = int'(cap_reg);
            if (cap < 1) cap = 1;
            if (cap > DEPTH) cap = DEPTH;
            full  = (held >= cap);
            pos   = held;
            place = 1'b1;
            if (held > 0) begin
                if ($signed(c.score) <= $signed(kept_score[held-1])) begin
                    if (full) place = 1'b0;
                end else begin
                    pos = held - 1;
                    for (i = held - 1; i >= 0; i--) begin
                        if ($signed(kept_score[i]) <= $signed(c.score)) pos = i;
                    end
                end
            end
            if (place) begin
                newc = full ? held : held + 1;
                for (i = newc - 1; i > pos; i--) begin
                    kept_row[i]   = kept_row[i-1];
                    kept_col[i]   = kept_col[i-1];
                    kept_score[i] = kept_score[i-1];
                end
                kept_row[pos]   = c.row;
                kept_col[pos]   = c.col;
                kept_score[pos] = c.score;
                held            = newc;
                r.accepted      = 1'b1;
                r.insert_rank   = RANK_W'(pos);
                r.dropped       = full;
            end
        end else if (int'(c.rank) < held) begin
            r.read_valid = 1'b1;
            r.out_row    = kept_row[c.rank];
            r.out_col    = kept_col[c.rank];
            r.out_score  = kept_score[c.rank];
        end
        r.entry_count = COUNT_W'(held);
        return r;
    endfunction

    function automatic t_point_cmd mk_cmd(logic cmd, int row, int col,
                                          logic signed [SCORE_W-1:0] score, int rank);
        t_point_cmd c;
        c.cmd   = cmd;
        c.row   = CB'(row);
        c.col   = CB'(col);
        c.score = score;
        c.rank  = RANK_W'(rank);
        return c;
    endfunction

    function automatic t_list_result res_of(bit acc, int rank, bit drop, int count);
        t_list_result r;
        r             = '0;
        r.accepted    = acc;
        r.insert_rank = RANK_W'(rank);
        r.dropped     = drop;
        r.entry_count = COUNT_W'(count);
        return r;
    endfunction

    function automatic string show(t_list_result r);
        return $sformatf("acc=%0d rank=%0d drop=%0d cnt=%0d rv=%0d row=%0d col=%0d score=%0d",
                         r.accepted, r.insert_rank, r.dropped, r.entry_count,
                         r.read_valid, r.out_row, r.out_col, r.out_score);
    endfunction

    function automatic t_point_cmd random_cmd();
        t_point_cmd c;
        int sel;
        int pick;
        c.cmd = ($urandom_range(99) < 35) ? CMD_READ : CMD_INSERT;
        c.row = CB'($urandom_range(4095));
        c.col = CB'($urandom_range(4095));
        sel   = $urandom_range(9);
        if (sel < 2) begin
            c.score = int'($urandom_range(16)) - 8;
        end else if (sel == 2) begin
            c.score = $urandom_range(1) ? S_MAX : S_MIN;
        end else if (sel < 6 && held > 0) begin
            pick    = $urandom_range(held - 1);
            c.score = kept_score[pick] + (int'($urandom_range(2)) - 1);
        end else begin
            c.score = $urandom;
        end
        if ($urandom_range(99) < 75)
            c.rank = RANK_W'((held > 63) ? $urandom_range(63) : $urandom_range(held));
        else
            c.rank = RANK_W'($urandom_range(63));
        return c;
    endfunction

    task automatic plan_beat(t_point_cmd c, bit known, t_list_result r);
        t_plan_row p;
        p.kind      = ROW_BEAT;
        p.beat      = c;
        p.known     = known;
        p.res       = r;
        p.cap_value = 0;
        plan        = {plan, p};
    endtask

    task automatic plan_cfg(int v);
        t_plan_row p;
        p.kind      = ROW_CFG;
        p.beat      = '0;
        p.known     = 1'b0;
        p.res       = '0;
        p.cap_value = v;
        plan        = {plan, p};
    endtask

    task automatic send_beat(t_point_cmd c, bit known, t_list_result r);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c.cmd;
        cmd_ch.point_row   <= c.row;
        cmd_ch.point_col   <= c.col;
        cmd_ch.point_score <= c.score;
        cmd_ch.read_rank   <= c.rank;
        beat_known         <= known;
        beat_res           <= r;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_cap(int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_POINTS));
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = COUNT_W'(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_INSERT;
        cmd_ch.point_row   = '0;
        cmd_ch.point_col   = '0;
        cmd_ch.point_score = '0;
        cmd_ch.read_rank   = '0;
        res_ch.ready       = 1'b0;
        beat_known         = 1'b0;
        beat_res           = '0;
        send_idle_pct      = 15;
        recv_idle_pct      = 84;
        hold_reqs          = 0;
        hold_seen          = 0;
        hold_left          = 0;
        mismatches         = 0;
        cycle_count        = 0;
        held               = 0;
        cap_reg            = MAX_POINTS_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            kept_row[i]   = '0;
            kept_col[i]   = '0;
            kept_score[i] = '0;
        end
    end

    // reset, directed table, then random phases
    initial begin
        int p;
        int n;
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 0), 1'b1, res_of(0, 0, 0, 0));
        plan_beat(mk_cmd(CMD_INSERT, 4095, 0, S_MAX, 0), 1'b1, res_of(1, 0, 0, 1));
        plan_cfg(0);
        // list full at one entry: lower score and tie with tail both rejected
        plan_beat(mk_cmd(CMD_INSERT, 0, 4095, S_MIN, 0), 1'b1, res_of(0, 0, 0, 1));
        plan_beat(mk_cmd(CMD_INSERT, 1, 1, S_MAX, 0), 1'b1, res_of(0, 0, 0, 1));
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 0), 1'b0, '0);
        plan_cfg(127);
        plan_beat(mk_cmd(CMD_INSERT, 0, 4095, S_MIN, 0), 1'b1, res_of(1, 1, 0, 2));
        plan_beat(mk_cmd(CMD_INSERT, 2, 3, 0, 0), 1'b0, '0);
        // tie with tail while not full appends
        plan_beat(mk_cmd(CMD_INSERT, 5, 5, S_MIN, 0), 1'b1, res_of(1, 3, 0, 4));
        plan_beat(mk_cmd(CMD_INSERT, 7, 7, S_MAX, 0), 1'b0, '0);
        plan_beat(mk_cmd(CMD_INSERT, 8, 8, -1, 0), 1'b0, '0);
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 0), 1'b0, '0);
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 5), 1'b0, '0);
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 6), 1'b1, res_of(0, 0, 0, 6));
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 63), 1'b1, res_of(0, 0, 0, 6));
        plan_beat(mk_cmd(CMD_READ, 4095, 4095, -1, 2), 1'b0, '0);
        plan_beat(mk_cmd(CMD_INSERT, 4095, 4095, 100, 63), 1'b0, '0);
        // capacity below held entries
        plan_cfg(3);
        plan_beat(mk_cmd(CMD_INSERT, 6, 6, S_MIN, 0), 1'b1, res_of(0, 0, 0, 7));
        plan_beat(mk_cmd(CMD_INSERT, 9, 9, 50, 0), 1'b0, '0);
        plan_beat(mk_cmd(CMD_READ, 0, 0, 0, 6), 1'b0, '0);
        plan_cfg(64);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_drained();
                write_cap(plan[k].cap_value);
            end else begin
                send_beat(plan[k].beat, plan[k].known, plan[k].res);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p < 2) begin
                send_idle_pct = 15;
                recv_idle_pct = 84;
            end else if (p < 4) begin
                send_idle_pct = 84;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cap(phase_cap[p]);
            for (n = 0; n < PHASE_BEATS; n++) begin
                if (p == 4 && n == 50) hold_reqs <= hold_reqs + 1;
                if (p == 4 && n == 150) wait_drained();
                send_beat(random_cmd(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("top_k_sorted_point_list: match");
        end else begin
            $display("top_k_sorted_point_list: mismatch");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen    <= hold_reqs;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // expectation per accepted command beat
    always @(posedge i_clk) begin
        t_point_cmd   c;
        t_list_result r;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c.cmd   = cmd_ch.command;
            c.row   = cmd_ch.point_row;
            c.col   = cmd_ch.point_col;
            c.score = cmd_ch.point_score;
            c.rank  = cmd_ch.read_rank;
            r = list_apply(c);
            if (beat_known) r = beat_res;
            pending_results = {pending_results, r};
        end
    end

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.accepted    = res_ch.accepted;
            got.insert_rank = res_ch.insert_rank;
            got.dropped     = res_ch.dropped;
            got.entry_count = res_ch.entry_count;
            got.read_valid  = res_ch.read_valid;
            got.out_row     = res_ch.out_row;
            got.out_col     = res_ch.out_col;
            got.out_score   = res_ch.out_score;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", show(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat differs\n  exp %s\n  got %s",
                                 show(want), show(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("top_k_sorted_point_list: mismatch");
            $finish;
        end
    end

endmodule

// File: sim.f
src/tksl_pkg.sv
src/tksl_if.sv
src/tksl_cfg.sv
src/tksl_cell.sv
src/top_k_sorted_point_list.sv
src/tksl_checker.sv
tb/sv/tb_top_k_sorted_point_list.sv
